### hw/rtl/ilt_pkg.sv
package ilt_pkg;

	localparam int POS_W  = 5;
	localparam int ELEM_W = 32;
	localparam int RD_W   = 32;
	localparam int FIDX_W = 4;
	localparam int CNT_W  = 5;

	typedef enum logic [2:0] {
		CMD_APPEND    = 3'd0,
		CMD_INSERT    = 3'd1,
		CMD_REMOVE    = 3'd2,
		CMD_READ      = 3'd3,
		CMD_OVERWRITE = 3'd4,
		CMD_FIND      = 3'd5,
		CMD_CLEAR     = 3'd6
	} ilt_cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_RANGE    = 2'd2,
		ST_NOTFOUND = 2'd3
	} ilt_status_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
		logic wr;
	} ilt_cell_ctrl_t;

	// packed so that read_value sits in the lowest bits
	typedef struct packed {
		ilt_status_t        status;
		logic [CNT_W-1:0]   count;
		logic [FIDX_W-1:0]  found_index;
		logic [RD_W-1:0]    read_value;
	} ilt_result_t;

endpackage

### hw/rtl/ilt_cell.sv
module ilt_cell #(
	parameter int WORD_WIDTH = 32,
	parameter int TW         = 5,
	parameter int CW         = 5,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  ilt_pkg::ilt_cell_ctrl_t ctrl,
	input  logic [TW-1:0]         tgt,
	input  logic [CW-1:0]         count,
	input  logic [WORD_WIDTH-1:0] elem,
	input  logic [WORD_WIDTH-1:0] left_word,
	input  logic [WORD_WIDTH-1:0] right_word,
	input  logic                  hit_in,
	output logic [WORD_WIDTH-1:0] word,
	output logic [WORD_WIDTH-1:0] sel_word,
	output logic                  hit_out,
	output logic                  first_hit
);

	localparam logic [TW-1:0] MY_T = TW'(IDX);
	localparam logic [CW-1:0] MY_C = CW'(IDX);

	logic [WORD_WIDTH-1:0] word_q;
	logic                  live;
	logic                  hit;

	assign live      = MY_C < count;
	assign hit       = live && (word_q == elem);
	assign hit_out   = hit_in | hit;
	assign first_hit = hit & ~hit_in;
	assign sel_word  = (MY_T == tgt) ? word_q : '0;
	assign word      = word_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (MY_T > tgt) begin
				word_q <= left_word;
			end else if (MY_T == tgt) begin
				word_q <= elem;
			end
		end else if (ctrl.del) begin
			if (MY_T >= tgt) begin
				word_q <= right_word;
			end
		end else if (ctrl.wr) begin
			if (MY_T == tgt) begin
				word_q <= elem;
			end
		end
	end

endmodule

### hw/rtl/indexed_list_table.sv
// indexed_list_table: ordered list of up to CAPACITY words held in a row of cells.
// s_tdata carries one request: cmd, position and elem_value. Every request
// returns exactly one result on m_tdata: read_value, found_index, count, status.
// Append, insert, remove, read, overwrite, find and clear are each handled in parallel:
// the cells shift, write and compare all entries together, and the find result
// ripples through the cell chain as a first-match flag. Each result is registered
// in the output or skid register before it shows on m_tvalid; one request per cycle is
// sustained while the receiver keeps m_tready high.
// Results go to an output register backed by a one-entry skid register, so a
// request is still taken while one result waits. With both full, s_tready drops
// until the receiver takes a result; nothing is lost or repeated.
// Reset empties the list (count zero) and the output side; entry contents are
// not cleared, since only entries below count are ever visible.
module indexed_list_table #(
	parameter int CAPACITY   = 16,
	parameter int WORD_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // cmd[2:0], position[7:3], elem_value[39:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // read_value[31:0], found_index[35:32], count[40:36],
	                              // status[42:41], zero[47:43]
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int TW = (CW > ilt_pkg::POS_W) ? CW : ilt_pkg::POS_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [2:0]                  cmd;
	logic [ilt_pkg::POS_W-1:0]   position;
	logic [ilt_pkg::ELEM_W-1:0]  elem_value;
	logic [63:0]                 val_wide;
	logic [WORD_WIDTH-1:0]       val;

	logic [CW-1:0]               count_q;
	logic [CW-1:0]               cnt_next;
	logic                        s_acc;
	logic                        full;
	logic                        pos_lt_cnt;
	logic                        pos_le_cnt;
	logic [TW-1:0]               tgt;
	ilt_pkg::ilt_cell_ctrl_t     ctrl;
	ilt_pkg::ilt_cell_ctrl_t     ctrl_g;
	ilt_pkg::ilt_result_t        res;
	ilt_pkg::ilt_result_t        out_q;
	ilt_pkg::ilt_result_t        skid_q;
	logic                        out_valid_q;
	logic                        skid_valid_q;
	logic                        m_take;

	logic [WORD_WIDTH-1:0]       words    [CAPACITY];
	logic [WORD_WIDTH-1:0]       sels     [CAPACITY];
	logic [WORD_WIDTH-1:0]       lefts    [CAPACITY];
	logic [WORD_WIDTH-1:0]       rights   [CAPACITY];
	logic [CAPACITY:0]           hits;
	logic [CAPACITY-1:0]         firsts;
	logic [IW-1:0]               found_idx;
	logic [WORD_WIDTH-1:0]       rd_or;
	logic [63:0]                 rd_wide;
	logic [31:0]                 fidx_wide;
	logic [31:0]                 tgt_wide;
	logic [31:0]                 cnt_wide;

	assign cmd        = s_tdata[2:0];
	assign position   = s_tdata[7:3];
	assign elem_value = s_tdata[39:8];
	assign val_wide   = 64'(elem_value);
	assign val        = val_wide[WORD_WIDTH-1:0];

	assign s_tready = ~skid_valid_q;
	assign s_acc    = s_tvalid & s_tready;
	assign m_tvalid = out_valid_q;
	assign m_take   = out_valid_q & m_tready;
	assign m_tdata  = {5'b0, out_q};

	assign full       = count_q >= CAP_C;
	assign pos_lt_cnt = TW'(position) < TW'(count_q);
	assign pos_le_cnt = TW'(position) <= TW'(count_q);

	assign hits[0] = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			if (gi == 0) begin : g_lo
				assign lefts[gi] = val;
			end else begin : g_mid_lo
				assign lefts[gi] = words[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_hi
				assign rights[gi] = '0;
			end else begin : g_mid_hi
				assign rights[gi] = words[gi+1];
			end
			ilt_cell #(
				.WORD_WIDTH (WORD_WIDTH),
				.TW         (TW),
				.CW         (CW),
				.IDX        (gi)
			) u_cell (
				.clk        (clk),
				.ctrl       (ctrl_g),
				.tgt        (tgt),
				.count      (count_q),
				.elem       (val),
				.left_word  (lefts[gi]),
				.right_word (rights[gi]),
				.hit_in     (hits[gi]),
				.word       (words[gi]),
				.sel_word   (sels[gi]),
				.hit_out    (hits[gi+1]),
				.first_hit  (firsts[gi])
			);
		end
	endgenerate

	always_comb begin
		found_idx = '0;
		rd_or     = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (firsts[i]) begin
				found_idx = found_idx | IW'(i);
			end
			rd_or = rd_or | sels[i];
		end
	end

	assign rd_wide   = 64'(rd_or);
	assign fidx_wide = 32'(found_idx);
	assign tgt_wide  = 32'(tgt);
	assign cnt_wide  = 32'(cnt_next);

	always_comb begin
		ctrl     = '0;
		tgt      = TW'(position);
		cnt_next = count_q;
		res      = '0;
		res.status = ilt_pkg::ST_OK;
		case (cmd)
			ilt_pkg::CMD_APPEND: begin
				tgt = TW'(count_q);
				if (full) begin
					res.status = ilt_pkg::ST_FULL;
				end else begin
					ctrl.ins            = 1'b1;
					cnt_next            = count_q + 1'b1;
					res.found_index     = tgt_wide[3:0];
				end
			end
			ilt_pkg::CMD_INSERT: begin
				if (!pos_le_cnt) begin
					res.status = ilt_pkg::ST_RANGE;
				end else if (full) begin
					res.status = ilt_pkg::ST_FULL;
				end else begin
					ctrl.ins            = 1'b1;
					cnt_next            = count_q + 1'b1;
					res.found_index     = tgt_wide[3:0];
				end
			end
			ilt_pkg::CMD_REMOVE: begin
				if (!pos_lt_cnt) begin
					res.status = ilt_pkg::ST_RANGE;
				end else begin
					ctrl.del = 1'b1;
					cnt_next = count_q - 1'b1;
				end
			end
			ilt_pkg::CMD_READ: begin
				if (!pos_lt_cnt) begin
					res.status = ilt_pkg::ST_RANGE;
				end else begin
					res.read_value = rd_wide[31:0];
				end
			end
			ilt_pkg::CMD_OVERWRITE: begin
				if (!pos_lt_cnt) begin
					res.status = ilt_pkg::ST_RANGE;
				end else begin
					ctrl.wr = 1'b1;
				end
			end
			ilt_pkg::CMD_FIND: begin
				if (hits[CAPACITY]) begin
					res.found_index = fidx_wide[3:0];
				end else begin
					res.status = ilt_pkg::ST_NOTFOUND;
				end
			end
			ilt_pkg::CMD_CLEAR: begin
				cnt_next = '0;
			end
			default: begin
			end
		endcase
		res.count = cnt_wide[4:0];
	end

	assign ctrl_g = s_acc ? ctrl : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (s_acc) begin
				count_q <= cnt_next;
			end
			if (m_take) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= s_acc;
				end
			end else if (s_acc) begin
				if (!out_valid_q) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (m_take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (s_acc) begin
				out_q <= res;
			end
		end else if (s_acc) begin
			if (!out_valid_q) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	// list never grows past its capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("count above capacity");

	// skid entry only exists behind a waiting result
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid valid without output valid");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && cmd == ilt_pkg::CMD_APPEND && !full) |=>
		(count_q == $past(count_q) + 1'b1))
		else $error("append did not grow list");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && cmd == ilt_pkg::CMD_CLEAR) |=> (count_q == '0))
		else $error("clear left entries");

	a_read_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && (cmd == ilt_pkg::CMD_READ || cmd == ilt_pkg::CMD_FIND)) |=>
		$stable(count_q))
		else $error("read or find changed count");

endmodule

### tb/ilt_checker.sv
module ilt_checker #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	output int          errors,
	output int          pending
);

	logic [ilt_pkg::ELEM_W-1:0] slots [CAPACITY];
	int                         fill;
	ilt_pkg::ilt_result_t       pending_results [$];
	ilt_pkg::ilt_result_t       want;
	ilt_pkg::ilt_result_t       got;

	initial begin
		errors  = 0;
		pending = 0;
		fill    = 0;
	end

	function automatic ilt_pkg::ilt_result_t list_apply(logic [2:0] cmd,
			logic [ilt_pkg::POS_W-1:0] pos, logic [ilt_pkg::ELEM_W-1:0] val);
		ilt_pkg::ilt_result_t r;
		r = '0;
		r.status = ilt_pkg::ST_OK;
		case (cmd)
			ilt_pkg::CMD_APPEND: begin
				if (fill >= CAPACITY) begin
					r.status = ilt_pkg::ST_FULL;
				end else begin
					slots[fill] = val;
					r.found_index = ilt_pkg::FIDX_W'(fill);
					fill++;
				end
			end
			ilt_pkg::CMD_INSERT: begin
				if (pos > fill) begin
					r.status = ilt_pkg::ST_RANGE;
				end else if (fill >= CAPACITY) begin
					r.status = ilt_pkg::ST_FULL;
				end else begin
					for (int i = fill; i > pos; i--)
						slots[i] = slots[i-1];
					slots[pos] = val;
					r.found_index = ilt_pkg::FIDX_W'(pos);
					fill++;
				end
			end
			ilt_pkg::CMD_REMOVE: begin
				if (pos >= fill) begin
					r.status = ilt_pkg::ST_RANGE;
				end else begin
					for (int i = pos; i + 1 < fill; i++)
						slots[i] = slots[i+1];
					fill--;
				end
			end
			ilt_pkg::CMD_READ: begin
				if (pos >= fill)
					r.status = ilt_pkg::ST_RANGE;
				else
					r.read_value = slots[pos];
			end
			ilt_pkg::CMD_OVERWRITE: begin
				if (pos >= fill)
					r.status = ilt_pkg::ST_RANGE;
				else
					slots[pos] = val;
			end
			ilt_pkg::CMD_FIND: begin
				r.status = ilt_pkg::ST_NOTFOUND;
				for (int i = 0; i < fill; i++) begin
					if (r.status == ilt_pkg::ST_NOTFOUND && slots[i] == val) begin
						r.found_index = ilt_pkg::FIDX_W'(i);
						r.status = ilt_pkg::ST_OK;
					end
				end
			end
			ilt_pkg::CMD_CLEAR: begin
				fill = 0;
			end
			default: begin
			end
		endcase
		r.count = ilt_pkg::CNT_W'(fill);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			pending_results.delete();
			pending = 0;
		end else begin
			if (s_tvalid && s_tready)
				pending_results.push_back(list_apply(s_tdata[2:0], s_tdata[7:3],
					s_tdata[39:8]));
			if (m_tvalid && m_tready) begin
				got = m_tdata[42:0];
				if (pending_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unrequested result: m_tdata %h", m_tdata);
				end else begin
					want = pending_results.pop_front();
					if (got !== want || m_tdata[47:43] !== '0) begin
						errors++;
						if (errors <= 10) begin
							$write("result mismatch (expected/actual): read_value %h/%h ",
								want.read_value, got.read_value);
							$display("found_index %0d/%0d count %0d/%0d status %0d/%0d pad 0/%h",
								want.found_index, got.found_index,
								want.count, got.count,
								want.status, got.status, m_tdata[47:43]);
						end
					end
				end
			end
			pending = pending_results.size();
		end
	end

endmodule

### tb/tb.sv
module tb;

	localparam int CAPACITY = 16;
	localparam int LIMIT = 300000;
	localparam int PHASE_ITEMS = 350;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [39:0] s_tdata = '0;
	logic        m_tready = 1'b0;
	logic        s_tready;
	logic        m_tvalid;
	logic [47:0] m_tdata;
	int          errors;
	int          pending;

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          fill_guess = 0;
	int          cycle_cnt = 0;
	bit          grow = 1'b1;
	logic [31:0] value_pool [8];

	int          idle_by_phase [4] = '{0, 85, 0, 17};
	int          stall_by_phase [4] = '{0, 0, 85, 17};
	logic [2:0]  cmd_order [8] = '{ilt_pkg::CMD_APPEND, ilt_pkg::CMD_INSERT,
		ilt_pkg::CMD_REMOVE, ilt_pkg::CMD_READ, ilt_pkg::CMD_OVERWRITE,
		ilt_pkg::CMD_FIND, ilt_pkg::CMD_CLEAR, CMD_UNUSED};
	int          cuts_grow [8] = '{30, 55, 62, 72, 80, 95, 97, 100};
	int          cuts_shrink [8] = '{8, 16, 50, 62, 70, 90, 93, 100};

	indexed_list_table #(
		.CAPACITY(CAPACITY),
		.WORD_WIDTH(ilt_pkg::ELEM_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	ilt_checker #(
		.CAPACITY(CAPACITY)
	) mon (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.errors(errors),
		.pending(pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("indexed_list_table regression: fail");
		$finish;
	end

	task automatic send_request(logic [2:0] cmd, logic [ilt_pkg::POS_W-1:0] pos,
			logic [31:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {val, pos, cmd};
		do @(posedge clk); while (!s_tready);
		case (cmd)
			ilt_pkg::CMD_APPEND: if (fill_guess < CAPACITY) fill_guess++;
			ilt_pkg::CMD_INSERT: if (pos <= fill_guess && fill_guess < CAPACITY) fill_guess++;
			ilt_pkg::CMD_REMOVE: if (pos < fill_guess) fill_guess--;
			ilt_pkg::CMD_CLEAR: fill_guess = 0;
			default: begin
			end
		endcase
	endtask

	// sender holds off until every result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic random_request();
		logic [2:0]                 cmd;
		logic [ilt_pkg::POS_W-1:0]  pos;
		logic [31:0]                val;
		int                         w;
		w = $urandom_range(99);
		cmd = CMD_UNUSED;
		for (int k = 7; k >= 0; k--)
			if (w < (grow ? cuts_grow[k] : cuts_shrink[k]))
				cmd = cmd_order[k];
		if ($urandom_range(4) == 0)
			pos = ilt_pkg::POS_W'($urandom_range(31));
		else if (cmd == ilt_pkg::CMD_INSERT)
			pos = ilt_pkg::POS_W'($urandom_range(fill_guess));
		else
			pos = (fill_guess == 0) ? '0 : ilt_pkg::POS_W'($urandom_range(fill_guess - 1));
		val = ($urandom_range(9) < 7) ? value_pool[$urandom_range(7)] : $urandom;
		send_request(cmd, pos, val);
	endtask

	initial begin
		value_pool[0] = '0;
		value_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			value_pool[i] = $urandom;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corners
		send_request(ilt_pkg::CMD_READ, 0, 0);
		send_request(ilt_pkg::CMD_REMOVE, 0, 0);
		send_request(ilt_pkg::CMD_FIND, 0, 0);
		send_request(ilt_pkg::CMD_INSERT, 1, 32'h1234_5678);
		send_request(ilt_pkg::CMD_INSERT, 0, 32'hffff_ffff);
		send_request(ilt_pkg::CMD_OVERWRITE, 1, 32'h0);
		send_request(CMD_UNUSED, 31, 32'ha5a5_a5a5);
		send_request(ilt_pkg::CMD_CLEAR, 0, 0);
		// fill to capacity, then full list corners
		for (int i = 0; i < CAPACITY; i++)
			send_request(ilt_pkg::CMD_APPEND, 0,
				(i == CAPACITY - 1) ? 32'hffff_ffff : i * 32'h0101_0101);
		send_request(ilt_pkg::CMD_APPEND, 0, 32'h5555_5555);
		send_request(ilt_pkg::CMD_INSERT, 16, 32'h5555_5555);
		send_request(ilt_pkg::CMD_INSERT, 17, 32'h5555_5555);
		send_request(ilt_pkg::CMD_READ, 15, 0);
		send_request(ilt_pkg::CMD_OVERWRITE, 15, 32'h0);
		send_request(ilt_pkg::CMD_FIND, 0, 32'hffff_ffff);
		send_request(ilt_pkg::CMD_FIND, 0, 32'h0);
		send_request(ilt_pkg::CMD_REMOVE, 0, 0);
		send_request(ilt_pkg::CMD_REMOVE, 16, 0);
		send_request(ilt_pkg::CMD_READ, 31, 0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_by_phase[ph];
			recv_stall_pct = stall_by_phase[ph];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(39) == 0)
					grow = !grow;
				random_request();
			end
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("indexed_list_table regression: pass");
		else
			$display("indexed_list_table regression: fail");
		$finish;
	end

endmodule
